### sv/sidep_pkg.sv
// Package for the SIMD issue/decode/execute timing pipeline.
// Holds buffer sizing, item structs, result kind codes and state codes.
// No dependencies.
package sidep_pkg;

  localparam int BUF_DEPTH = 8;
  localparam int IDX_W = $clog2(BUF_DEPTH);
  localparam int CNT_W = $clog2(BUF_DEPTH + 1);
  localparam logic [3:0] MAX_WIDTH = 4'd8;

  // Result kinds.
  localparam logic [1:0] KIND_COMPLETE = 2'd0;
  localparam logic [1:0] KIND_POOL_READY = 2'd1;
  localparam logic [1:0] KIND_ENQ_ANSWER = 2'd2;
  localparam logic [1:0] KIND_TICK_END = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DECODE_LAT = 2'd0;
  localparam logic [1:0] CFG_EXEC_LAT = 2'd1;
  localparam logic [1:0] CFG_STAGE_WIDTH = 2'd2;

  typedef struct packed {
    logic        action;
    logic [15:0] uop_tag;
    logic [5:0]  pool_entry;
    logic [7:0]  ready_after;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] out_tag;
    logic [5:0]  out_pool_entry;
    logic        accepted;
    logic        idle;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [5:0]  pool;
    logic [31:0] ready;
  } entry_t;

  // Control from the sequencer to one buffer.
  typedef struct packed {
    logic             rm;
    logic             app;
    logic [CNT_W-1:0] pos;
  } buf_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COMP,
    S_EXEC,
    S_DEC,
    S_END
  } state_t;

endpackage

### sv/sidep_cell.sv
// One buffer cell: holds a single entry and takes its right neighbor's
// entry when the buffer closes a gap. Depends on sidep_pkg.
module sidep_cell (
  input  logic            clk,
  input  logic            shift,
  input  logic            load,
  input  sidep_pkg::entry_t nbr,
  input  sidep_pkg::entry_t new_entry,
  output sidep_pkg::entry_t q
);
  import sidep_pkg::*;

  // A removal shifts data down the row; an append writes the first free cell.
  always_ff @(posedge clk) begin
    if (shift) begin
      q <= nbr;
    end else if (load) begin
      q <= new_entry;
    end
  end

endmodule

### sv/sidep_buffer.sv
// Ordered buffer built as a row of cells, oldest entry in cell zero.
// Supports removal at a position and append at the tail. Depends on sidep_pkg.
module sidep_buffer (
  input  logic                       clk,
  input  logic                       rst,
  input  sidep_pkg::buf_ctrl_t       ctrl,
  input  sidep_pkg::entry_t          app_data,
  output sidep_pkg::entry_t          rd_data,
  output logic [sidep_pkg::CNT_W-1:0] count
);
  import sidep_pkg::*;

  entry_t cells [BUF_DEPTH];
  logic [CNT_W-1:0] count_next;

  // Row of cells; each one hands its entry to its left neighbor on removal.
  for (genvar i = 0; i < BUF_DEPTH; i++) begin : g_cell
    logic   sh;
    logic   ld;
    entry_t nb;
    assign sh = ctrl.rm && (CNT_W'(i) >= ctrl.pos) && (i < BUF_DEPTH - 1);
    assign ld = ctrl.app && (CNT_W'(i) == count);
    if (i < BUF_DEPTH - 1) begin : g_mid
      assign nb = cells[i + 1];
    end else begin : g_tail
      assign nb = cells[i];
    end
    sidep_cell u_cell (
      .clk       (clk),
      .shift     (sh),
      .load      (ld),
      .nbr       (nb),
      .new_entry (app_data),
      .q         (cells[i])
    );
  end

  assign rd_data = cells[ctrl.pos[IDX_W-1:0]];

  // Fill count.
  always_comb begin
    count_next = count;
    if (ctrl.rm) begin
      count_next = count - CNT_W'(1);
    end else if (ctrl.app) begin
      count_next = count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

### sv/simd_issue_decode_exec_pipeline_top.sv
// Top level of the SIMD issue/decode/execute timing pipeline: tick
// sequencer, configuration registers, output register and three buffers.
// Depends on sidep_pkg, sidep_buffer and sidep_cell.
//
//   channel  signals                       direction
//   in       in_valid/in_ready/in_item     enqueue or tick item in
//   out      out_valid/out_ready/out_item  result items out
//   cfg      cfg_valid/cfg_ready/cfg_index/cfg_data  register writes in
//
// A tick is accepted, then the sequencer scans the execute, decode and issue
// buffers in turn, each over the fill count it has when its scan starts,
// stepping one entry per cycle while the output register is not stalled,
// and then emits the tick end. Reset is synchronous; it clears the buffer
// counts, cycle count and sequencer registers and loads the configuration
// registers with their defaults. A stalled output register holds the
// sequencer whenever it must emit.
module simd_issue_decode_exec_pipeline_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sidep_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sidep_pkg::out_item_t out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data
);
  import sidep_pkg::*;

  state_t state, state_next;
  logic [7:0]  decode_latency;
  logic [7:0]  exec_latency;
  logic [3:0]  stage_width;
  logic [31:0] cycle_count;
  logic [CNT_W-1:0] pos, pos_next;
  logic [CNT_W-1:0] n, n_next;
  logic [CNT_W-1:0] total, total_next;
  logic        idle_flag, idle_flag_next;

  buf_ctrl_t  iss_ctrl, dec_ctrl, exe_ctrl;
  entry_t     iss_rd, dec_rd, exe_rd;
  entry_t     iss_app, dec_app, exe_app;
  logic [CNT_W-1:0] iss_cnt, dec_cnt, exe_cnt;

  logic       can_emit;
  logic       emit;
  out_item_t  emit_item;
  logic       in_acc;
  logic       cyc_inc;
  logic [3:0] width_sat;
  logic       scan_done;
  logic       move_exec, move_dec, comp_hit;

  assign cfg_ready = 1'b1;
  assign can_emit  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE) && can_emit;
  assign in_acc    = in_valid && in_ready;
  assign width_sat = (stage_width > MAX_WIDTH) ? MAX_WIDTH : stage_width;
  assign scan_done = (n == total);

  assign comp_hit  = cycle_count >= exe_rd.ready;
  assign move_exec = (cycle_count >= dec_rd.ready) && ({1'b0, n} < {1'b0, width_sat})
                     && (exe_cnt < CNT_W'(BUF_DEPTH));
  assign move_dec  = (cycle_count >= iss_rd.ready) && ({1'b0, n} < {1'b0, width_sat})
                     && (dec_cnt < CNT_W'(BUF_DEPTH));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      decode_latency <= 8'd1;
      exec_latency   <= 8'd8;
      stage_width    <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DECODE_LAT:  decode_latency <= cfg_data;
        CFG_EXEC_LAT:    exec_latency   <= cfg_data;
        CFG_STAGE_WIDTH: stage_width    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Next state and scan counters.
  always_comb begin
    state_next     = state;
    pos_next       = pos;
    n_next         = n;
    total_next     = total;
    idle_flag_next = idle_flag;
    unique case (state)
      S_IDLE: begin
        if (in_acc && !in_item.action) begin
          idle_flag_next = (exe_cnt == '0);
          total_next     = exe_cnt;
          pos_next       = '0;
          n_next         = '0;
          state_next     = S_COMP;
        end
      end
      S_COMP: begin
        if (scan_done) begin
          total_next = dec_cnt;
          pos_next   = '0;
          n_next     = '0;
          state_next = S_EXEC;
        end else if (!comp_hit) begin
          pos_next = pos + CNT_W'(1);
          n_next   = n + CNT_W'(1);
        end else if (can_emit) begin
          n_next = n + CNT_W'(1);
        end
      end
      S_EXEC: begin
        if (scan_done) begin
          total_next = iss_cnt;
          pos_next   = '0;
          n_next     = '0;
          state_next = S_DEC;
        end else if (!move_exec) begin
          pos_next = pos + CNT_W'(1);
          n_next   = n + CNT_W'(1);
        end else if (can_emit) begin
          n_next = n + CNT_W'(1);
        end
      end
      S_DEC: begin
        if (scan_done) begin
          state_next = S_END;
        end else begin
          n_next = n + CNT_W'(1);
          if (!move_dec) begin
            pos_next = pos + CNT_W'(1);
          end
        end
      end
      S_END: begin
        if (can_emit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Buffer controls and emitted items.
  always_comb begin
    iss_ctrl  = '{rm: 1'b0, app: 1'b0, pos: pos};
    dec_ctrl  = '{rm: 1'b0, app: 1'b0, pos: pos};
    exe_ctrl  = '{rm: 1'b0, app: 1'b0, pos: pos};
    iss_app   = '{tag: in_item.uop_tag, pool: in_item.pool_entry,
                  ready: cycle_count + {24'd0, in_item.ready_after}};
    dec_app   = '{tag: iss_rd.tag, pool: iss_rd.pool,
                  ready: cycle_count + {24'd0, decode_latency}};
    exe_app   = '{tag: dec_rd.tag, pool: dec_rd.pool,
                  ready: cycle_count + {24'd0, exec_latency}};
    emit      = 1'b0;
    emit_item = '0;
    cyc_inc   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_acc && in_item.action) begin
          emit                   = 1'b1;
          emit_item.kind         = KIND_ENQ_ANSWER;
          emit_item.out_tag      = in_item.uop_tag;
          emit_item.out_pool_entry = in_item.pool_entry;
          emit_item.accepted     = (iss_cnt < CNT_W'(BUF_DEPTH));
          emit_item.last         = 1'b1;
          iss_ctrl.app           = (iss_cnt < CNT_W'(BUF_DEPTH));
        end
      end
      S_COMP: begin
        if (!scan_done && comp_hit && can_emit) begin
          emit              = 1'b1;
          emit_item.kind    = KIND_COMPLETE;
          emit_item.out_tag = exe_rd.tag;
          exe_ctrl.rm       = 1'b1;
        end
      end
      S_EXEC: begin
        if (!scan_done && move_exec && can_emit) begin
          emit                     = 1'b1;
          emit_item.kind           = KIND_POOL_READY;
          emit_item.out_tag        = dec_rd.tag;
          emit_item.out_pool_entry = dec_rd.pool;
          dec_ctrl.rm              = 1'b1;
          exe_ctrl.app             = 1'b1;
        end
      end
      S_DEC: begin
        if (!scan_done && move_dec) begin
          iss_ctrl.rm  = 1'b1;
          dec_ctrl.app = 1'b1;
        end
      end
      S_END: begin
        if (can_emit) begin
          emit           = 1'b1;
          emit_item.kind = KIND_TICK_END;
          emit_item.idle = idle_flag;
          emit_item.last = 1'b1;
          cyc_inc        = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cycle_count <= '0;
      pos         <= '0;
      n           <= '0;
      total       <= '0;
      idle_flag   <= 1'b0;
    end else begin
      state     <= state_next;
      pos       <= pos_next;
      n         <= n_next;
      total     <= total_next;
      idle_flag <= idle_flag_next;
      if (cyc_inc) begin
        cycle_count <= cycle_count + 32'd1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item <= emit_item;
    end
  end

  sidep_buffer u_issue (
    .clk (clk), .rst (rst), .ctrl (iss_ctrl), .app_data (iss_app),
    .rd_data (iss_rd), .count (iss_cnt)
  );

  sidep_buffer u_decode (
    .clk (clk), .rst (rst), .ctrl (dec_ctrl), .app_data (dec_app),
    .rd_data (dec_rd), .count (dec_cnt)
  );

  sidep_buffer u_exec (
    .clk (clk), .rst (rst), .ctrl (exe_ctrl), .app_data (exe_app),
    .rd_data (exe_rd), .count (exe_cnt)
  );

endmodule
